>>> hw/rtl/sat_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sat_pkg
// Shared types, character codes and helpers for the shell arithmetic
// tokenizer.
// ----------------------------------------------------------------------------
package sat_pkg;

    // Deepest parenthesis nesting tracked inside a subshell token.
    localparam int unsigned MAX_DEPTH = 255;
    localparam int unsigned DEPTH_W   = $clog2(MAX_DEPTH + 1);

    // Queue between the classifier and the token engine.
    localparam int unsigned FIFO_AW    = 2;
    localparam int unsigned FIFO_DEPTH = 1 << FIFO_AW;

    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_PIPE   = 8'h7C;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_TILDE  = 8'h7E;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    localparam logic [1:0] KIND_WORD = 2'd0;
    localparam logic [1:0] KIND_OP   = 2'd1;
    localparam logic [1:0] KIND_SUB  = 2'd2;

    typedef enum logic [4:0] {
        MODE_IDLE   = 5'b00001,
        MODE_WORD   = 5'b00010,
        MODE_DOLLAR = 5'b00100,
        MODE_OP     = 5'b01000,
        MODE_SUB    = 5'b10000
    } mode_t;

    // One classified input transaction as it sits in the queue.
    typedef struct packed {
        logic [7:0] ch;
        logic       eoi;
        logic       is_op;
        logic       is_space;
        logic       is_brk;     // operator, space or newline: ends a word
        logic       is_dollar;
        logic       is_lparen;
        logic       is_rparen;
    } char_item_t;

    function automatic logic is_op_char(input logic [7:0] c);
        return (c == CH_MINUS) || (c == CH_PLUS) || (c == CH_STAR) ||
               (c == CH_SLASH) || (c == CH_AMP) || (c == CH_PIPE) ||
               (c == CH_BANG) || (c == CH_TILDE);
    endfunction

endpackage

>>> hw/rtl/shell_arith_tokenizer.sv
`timescale 1ns / 1ps
// A character accepted at the input is written into the queue, and the token engine then registers its result.
// Throughput: one character per cycle while m_tready does not stall the result channel.
// The four-entry queue lets the input keep flowing while a result waits to be taken.
// A skipped space is consumed without producing a result transaction.
// Reset (aresetn low, synchronous) empties the queue, drops any pending result and
// returns the tokenizer to the idle state between tokens.
// ----------------------------------------------------------------------------
// shell_arith_tokenizer
// Character-stream tokenizer for shell arithmetic text.
// ----------------------------------------------------------------------------
module shell_arith_tokenizer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] ch
    input  logic        s_tlast,   // end_of_input
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_ch
    output logic [3:0]  m_tuser,   // [0] starts_token, [2:1] token_kind, [3] syntax_error
    output logic        m_tlast    // done_res
);

    sat_pkg::char_item_t push_item;
    sat_pkg::char_item_t head_item;
    logic                q_push;
    logic                q_pop;
    logic                q_full;
    logic                q_empty;

    sat_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (push_item)
    );

    sat_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head_item (head_item)
    );

    sat_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_item   (head_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

>>> hw/rtl/sat_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sat_front
// Accepts input transactions and classifies each character for the token
// engine.
// ----------------------------------------------------------------------------
module sat_front (
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] ch
    input  logic                  s_tlast,   // end_of_input
    input  logic                  q_full,
    output logic                  q_push,
    output sat_pkg::char_item_t   q_item
);

    logic is_op;
    logic is_space;

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    assign is_op    = sat_pkg::is_op_char(s_tdata);
    assign is_space = (s_tdata == sat_pkg::CH_SPACE);

    always_comb begin
        q_item.ch        = s_tdata;
        q_item.eoi       = s_tlast;
        q_item.is_op     = is_op;
        q_item.is_space  = is_space;
        q_item.is_brk    = is_op || is_space || (s_tdata == sat_pkg::CH_NL);
        q_item.is_dollar = (s_tdata == sat_pkg::CH_DOLLAR);
        q_item.is_lparen = (s_tdata == sat_pkg::CH_LPAREN);
        q_item.is_rparen = (s_tdata == sat_pkg::CH_RPAREN);
    end

endmodule

>>> hw/rtl/sat_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sat_fifo
// Short first-word-fall-through queue of classified characters between the
// front and back parts.
// ----------------------------------------------------------------------------
module sat_fifo (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  sat_pkg::char_item_t   push_item,
    output logic                  full,
    input  logic                  pop,
    output logic                  empty,
    output sat_pkg::char_item_t   head_item
);

    sat_pkg::char_item_t                  mem_reg [sat_pkg::FIFO_DEPTH];
    logic [sat_pkg::FIFO_AW-1:0]          wr_ptr_reg, wr_ptr_next;
    logic [sat_pkg::FIFO_AW-1:0]          rd_ptr_reg, rd_ptr_next;
    logic [sat_pkg::FIFO_AW:0]            count_reg, count_next;

    assign full      = (count_reg == (sat_pkg::FIFO_AW+1)'(sat_pkg::FIFO_DEPTH));
    assign empty     = (count_reg == '0);
    assign head_item = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

>>> hw/rtl/sat_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sat_back
// Token engine: walks the tokenizer mode for each queued character and
// drives the registered result channel.
// ----------------------------------------------------------------------------
module sat_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  q_empty,
    input  sat_pkg::char_item_t   q_item,
    output logic                  q_pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,   // [7:0] out_ch
    output logic [3:0]            m_tuser,   // [0] starts_token, [2:1] token_kind,
                                             // [3] syntax_error
    output logic                  m_tlast    // done_res
);

    sat_pkg::mode_t                 mode_reg, mode_next;
    logic [7:0]                     held_reg, held_next;
    logic [sat_pkg::DEPTH_W-1:0]    depth_reg, depth_next, depth_dec;
    logic                           err_reg, err_next;

    logic                           valid_reg, valid_next;
    logic [7:0]                     ch_reg, ch_next;
    logic                           start_reg, start_next;
    logic [1:0]                     kind_reg, kind_next;
    logic                           done_reg, done_next;
    logic                           serr_reg, serr_next;

    logic                           has_res;
    logic                           new_token;
    logic                           out_free;

    assign out_free = !valid_reg || m_tready;
    assign q_pop    = !q_empty && out_free;

    assign depth_dec = (depth_reg != '0) ? depth_reg - 1'b1 : depth_reg;

    always_comb begin
        mode_next  = mode_reg;
        held_next  = held_reg;
        depth_next = depth_reg;
        err_next   = err_reg;
        has_res    = 1'b1;
        new_token  = 1'b0;
        ch_next    = q_item.ch;
        start_next = 1'b0;
        kind_next  = sat_pkg::KIND_WORD;
        done_next  = 1'b0;
        serr_next  = 1'b0;

        if (q_item.eoi) begin
            ch_next    = '0;
            done_next  = 1'b1;
            serr_next  = err_reg || (mode_reg == sat_pkg::MODE_SUB);
            mode_next  = sat_pkg::MODE_IDLE;
            held_next  = '0;
            depth_next = '0;
            err_next   = 1'b0;
        end else begin
            unique case (mode_reg)
                sat_pkg::MODE_SUB: begin
                    kind_next = sat_pkg::KIND_SUB;
                    if (q_item.is_lparen) begin
                        if (depth_reg >= sat_pkg::DEPTH_W'(sat_pkg::MAX_DEPTH)) begin
                            err_next   = 1'b1;
                            depth_next = sat_pkg::DEPTH_W'(sat_pkg::MAX_DEPTH);
                        end else begin
                            depth_next = depth_reg + 1'b1;
                        end
                    end else if (q_item.is_rparen) begin
                        depth_next = depth_dec;
                        if (depth_dec == '0) begin
                            mode_next = sat_pkg::MODE_IDLE;
                        end
                    end
                end
                sat_pkg::MODE_OP: begin
                    if (q_item.ch == held_reg) begin
                        mode_next = sat_pkg::MODE_IDLE;
                        held_next = '0;
                        kind_next = sat_pkg::KIND_OP;
                    end else begin
                        held_next = '0;
                        new_token = 1'b1;
                    end
                end
                sat_pkg::MODE_DOLLAR: begin
                    if (q_item.is_lparen) begin
                        mode_next  = sat_pkg::MODE_SUB;
                        depth_next = sat_pkg::DEPTH_W'(1);
                        kind_next  = sat_pkg::KIND_SUB;
                    end else if (!q_item.is_brk) begin
                        mode_next = sat_pkg::MODE_WORD;
                    end else begin
                        new_token = 1'b1;
                    end
                end
                sat_pkg::MODE_WORD: begin
                    if (q_item.is_brk) begin
                        new_token = 1'b1;
                    end
                end
                sat_pkg::MODE_IDLE: begin
                    new_token = 1'b1;
                end
                default: begin
                    new_token = 1'b1;
                end
            endcase

            if (new_token) begin
                if (q_item.is_space) begin
                    mode_next = sat_pkg::MODE_IDLE;
                    has_res   = 1'b0;
                end else if (q_item.is_op) begin
                    mode_next  = sat_pkg::MODE_OP;
                    held_next  = q_item.ch;
                    start_next = 1'b1;
                    kind_next  = sat_pkg::KIND_OP;
                end else begin
                    mode_next  = q_item.is_dollar ? sat_pkg::MODE_DOLLAR
                                                  : sat_pkg::MODE_WORD;
                    start_next = 1'b1;
                    kind_next  = sat_pkg::KIND_WORD;
                end
            end
        end
    end

    // A skipped space is popped without loading a result.
    always_comb begin
        if (q_pop) begin
            valid_next = has_res;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= sat_pkg::MODE_IDLE;
            held_reg  <= '0;
            depth_reg <= '0;
            err_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            if (q_pop) begin
                mode_reg  <= mode_next;
                held_reg  <= held_next;
                depth_reg <= depth_next;
                err_reg   <= err_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            ch_reg    <= ch_next;
            start_reg <= start_next;
            kind_reg  <= kind_next;
            done_reg  <= done_next;
            serr_reg  <= serr_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = ch_reg;
    assign m_tuser  = {serr_reg, kind_reg, start_reg};
    assign m_tlast  = done_reg;

endmodule

>>> hw/rtl/sat_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sat_checker
// Port-level checks on the tokenizer result stream.
// ----------------------------------------------------------------------------
module sat_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic [3:0]  m_tuser,
    input logic        m_tlast
);

    // The done transaction carries no character, start mark or kind.
    a_done_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> (m_tdata == 8'h00) && (m_tuser[2:0] == 3'b000))
        else $error("done result carries token payload");

    // The error flag only appears on the done transaction.
    a_err_only_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !m_tuser[3])
        else $error("syntax_error outside done result");

    // A continuing operator character is the second half of a doubled operator.
    a_op_cont: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast && !m_tuser[0] && (m_tuser[2:1] == sat_pkg::KIND_OP) |->
        (m_tdata == sat_pkg::CH_MINUS) || (m_tdata == sat_pkg::CH_PLUS) ||
        (m_tdata == sat_pkg::CH_STAR) || (m_tdata == sat_pkg::CH_SLASH) ||
        (m_tdata == sat_pkg::CH_AMP) || (m_tdata == sat_pkg::CH_PIPE) ||
        (m_tdata == sat_pkg::CH_BANG) || (m_tdata == sat_pkg::CH_TILDE))
        else $error("operator continuation on a non-operator character");

    // A stalled result stays put.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
        $stable(m_tlast))
        else $error("result changed while stalled");

endmodule

bind shell_arith_tokenizer sat_checker u_sat_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

>>> verif/tb_shell_arith_tokenizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_shell_arith_tokenizer
// Self-checking testbench for the shell arithmetic tokenizer. A driver feeds
// characters from a queue and a tracking model of the token rules predicts
// each result. A monitor compares every result transaction with the oldest
// prediction. The stimulus starts with short directed texts. Random token
// sequences follow under several idling patterns, one long receiver stall
// and one deep parenthesis nest.
// ----------------------------------------------------------------------------
module tb_shell_arith_tokenizer;
    import sat_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic       eoi;
        logic [7:0] ch;
    } char_txn_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       starts;
        logic [1:0] kind;
        logic       done;
        logic       err;
    } token_result_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;
    logic       s_tlast = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic [3:0] m_tuser;
    logic       m_tlast;

    char_txn_t     pending_chars[$];
    token_result_t expected_tokens[$];
    char_txn_t     next_char;
    int unsigned   chars_queued = 0;
    int unsigned   error_count = 0;
    int unsigned   cycle_count = 0;
    int unsigned   send_idle_pct = 0;
    int unsigned   recv_idle_pct = 0;
    logic          recv_hold = 1'b0;
    logic          stall_go = 1'b0;

    // Tracked tokenizer state.
    mode_t       tok_mode = MODE_IDLE;
    logic [7:0]  tok_held = 8'h00;
    int unsigned tok_depth = 0;
    logic        tok_err = 1'b0;

    shell_arith_tokenizer u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic logic is_operator(input logic [7:0] c);
        case (c)
            CH_MINUS, CH_PLUS, CH_STAR, CH_SLASH,
            CH_AMP, CH_PIPE, CH_BANG, CH_TILDE: is_operator = 1'b1;
            default: is_operator = 1'b0;
        endcase
    endfunction

    function automatic logic ends_word(input logic [7:0] c);
        ends_word = is_operator(c) || (c == CH_SPACE) || (c == CH_NL);
    endfunction

    // Advances the tracked state by one accepted character and queues the
    // result it produces, if any.
    task automatic track_tokenizer(input logic [7:0] c, input logic eoi);
        token_result_t r;
        logic          emit;
        logic          fresh;
        r     = '0;
        emit  = 1'b1;
        fresh = 1'b0;
        if (eoi) begin
            r.done    = 1'b1;
            r.err     = tok_err | (tok_mode == MODE_SUB);
            tok_mode  = MODE_IDLE;
            tok_held  = 8'h00;
            tok_depth = 0;
            tok_err   = 1'b0;
        end else if (tok_mode == MODE_SUB) begin
            if (c == CH_LPAREN) begin
                if (tok_depth >= MAX_DEPTH) begin
                    tok_err   = 1'b1;
                    tok_depth = MAX_DEPTH;
                end else begin
                    tok_depth++;
                end
            end else if (c == CH_RPAREN) begin
                if (tok_depth > 0)
                    tok_depth--;
                if (tok_depth == 0)
                    tok_mode = MODE_IDLE;
            end
            r.ch   = c;
            r.kind = KIND_SUB;
        end else begin
            fresh = 1'b1;
            if (tok_mode == MODE_OP) begin
                if (c == tok_held) begin
                    tok_mode = MODE_IDLE;
                    r.ch     = c;
                    r.kind   = KIND_OP;
                    fresh    = 1'b0;
                end
                tok_held = 8'h00;
            end else if (tok_mode == MODE_DOLLAR && c == CH_LPAREN) begin
                tok_mode  = MODE_SUB;
                tok_depth = 1;
                r.ch      = c;
                r.kind    = KIND_SUB;
                fresh     = 1'b0;
            end else if ((tok_mode == MODE_WORD || tok_mode == MODE_DOLLAR) &&
                         !ends_word(c)) begin
                tok_mode = MODE_WORD;
                r.ch     = c;
                r.kind   = KIND_WORD;
                fresh    = 1'b0;
            end
            if (fresh) begin
                if (c == CH_SPACE) begin
                    tok_mode = MODE_IDLE;
                    emit     = 1'b0;
                end else if (is_operator(c)) begin
                    tok_mode = MODE_OP;
                    tok_held = c;
                    r.ch     = c;
                    r.starts = 1'b1;
                    r.kind   = KIND_OP;
                end else begin
                    tok_mode = (c == CH_DOLLAR) ? MODE_DOLLAR : MODE_WORD;
                    r.ch     = c;
                    r.starts = 1'b1;
                    r.kind   = KIND_WORD;
                end
            end
        end
        if (emit)
            expected_tokens.push_back(r);
    endtask

    task automatic compare_field(input string name, input logic [7:0] want,
                                 input logic [7:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                     $time, name, want, got);
            error_count++;
        end
    endtask

    task automatic check_token(input token_result_t got);
        token_result_t want;
        if (expected_tokens.size() == 0) begin
            $display("%0t ns: unexpected result, expected none, actual %h", $time, got);
            error_count++;
        end else begin
            want = expected_tokens.pop_front();
            compare_field("out_ch", want.ch, got.ch);
            compare_field("starts_token", want.starts, got.starts);
            compare_field("token_kind", want.kind, got.kind);
            compare_field("done", want.done, got.done);
            compare_field("syntax_error", want.err, got.err);
        end
    endtask

    // Driver: records the accepted transaction, then offers the next one.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                track_tokenizer(s_tdata, s_tlast);
            if (!s_tvalid || s_tready) begin
                if (pending_chars.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_char = pending_chars.pop_front();
                    s_tdata  <= next_char.ch;
                    s_tlast  <= next_char.eoi;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result transaction and throttles m_tready.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready)
                check_token({m_tdata, m_tuser[0], m_tuser[2:1], m_tlast, m_tuser[3]});
            m_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Long receiver stall while the sender keeps offering characters.
    initial begin
        wait (stall_go);
        @(posedge aclk);
        recv_hold <= 1'b1;
        repeat (80) @(posedge aclk);
        recv_hold <= 1'b0;
    end

    task automatic push_ch(input logic [7:0] c);
        pending_chars.push_back('{eoi: 1'b0, ch: c});
        chars_queued++;
    endtask

    task automatic push_eoi();
        pending_chars.push_back('{eoi: 1'b1, ch: 8'($urandom_range(255))});
        chars_queued++;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_ch(s[i]);
    endtask

    function automatic logic [7:0] pick_operator();
        case ($urandom_range(7))
            0: pick_operator = CH_MINUS;
            1: pick_operator = CH_PLUS;
            2: pick_operator = CH_STAR;
            3: pick_operator = CH_SLASH;
            4: pick_operator = CH_AMP;
            5: pick_operator = CH_PIPE;
            6: pick_operator = CH_BANG;
            default: pick_operator = CH_TILDE;
        endcase
    endfunction

    function automatic logic [7:0] pick_word_char();
        logic [7:0] c;
        if ($urandom_range(9) < 7) begin
            c = ($urandom_range(1) == 0) ? 8'h61 + 8'($urandom_range(25))
                                         : 8'h30 + 8'($urandom_range(9));
        end else begin
            c = 8'($urandom_range(255));
            while (ends_word(c))
                c = 8'($urandom_range(255));
        end
        pick_word_char = c;
    endfunction

    // Subshell with balanced, randomly nested content; sometimes cut short
    // by end of input.
    task automatic push_subshell();
        int unsigned depth;
        int unsigned body;
        logic [7:0]  c;
        depth = 1;
        body  = $urandom_range(8);
        push_ch(CH_DOLLAR);
        push_ch(CH_LPAREN);
        for (int i = 0; i < body; i++) begin
            case ($urandom_range(5))
                0: begin
                    c = CH_LPAREN;
                    depth++;
                end
                1: begin
                    if (depth > 1) begin
                        c = CH_RPAREN;
                        depth--;
                    end else begin
                        c = CH_SPACE;
                    end
                end
                2: c = pick_operator();
                3: c = CH_SPACE;
                default: begin
                    c = 8'($urandom_range(255));
                    if (c == CH_LPAREN || c == CH_RPAREN)
                        c = CH_DOLLAR;
                end
            endcase
            push_ch(c);
        end
        if ($urandom_range(9) == 0) begin
            push_eoi();
        end else begin
            for (int i = 0; i < depth; i++)
                push_ch(CH_RPAREN);
        end
    endtask

    task automatic push_token();
        int unsigned pick;
        int unsigned len;
        logic [7:0]  op;
        pick = $urandom_range(99);
        if (pick < 35) begin
            len = $urandom_range(1, 6);
            if ($urandom_range(4) == 0)
                push_ch(CH_DOLLAR);
            for (int i = 0; i < len; i++)
                push_ch(pick_word_char());
            if ($urandom_range(6) == 0) begin
                push_ch(CH_DOLLAR);
                push_ch(CH_LPAREN);
            end
        end else if (pick < 60) begin
            op  = pick_operator();
            len = ($urandom_range(5) == 0) ? 3 : $urandom_range(1, 2);
            for (int i = 0; i < len; i++)
                push_ch(op);
        end else if (pick < 75) begin
            push_subshell();
        end else if (pick < 85) begin
            len = $urandom_range(1, 3);
            for (int i = 0; i < len; i++)
                push_ch(CH_SPACE);
        end else if (pick < 92) begin
            push_ch(CH_NL);
        end else begin
            push_ch(8'($urandom_range(255)));
        end
        if ($urandom_range(1) == 0)
            push_ch(CH_SPACE);
        if ($urandom_range(29) == 0)
            push_eoi();
    endtask

    task automatic push_random_text(input int unsigned count);
        int unsigned start;
        start = chars_queued;
        while (chars_queued - start < count)
            push_token();
    endtask

    // Waits until the driver has sent everything and every result is back.
    task automatic wait_drained();
        @(negedge aclk);
        while (pending_chars.size() > 0 || s_tvalid || expected_tokens.size() > 0)
            @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        send_idle_pct = 7;
        recv_idle_pct = 61;
        push_text("x --y");
        push_text("***");
        push_text("$((b))");
        push_text("$z");
        push_text("w$(");
        push_ch(8'h00);
        push_ch(8'hFF);
        push_ch(CH_NL);
        push_text("+&|!~/");
        push_text("$(");
        push_eoi();
        push_random_text(140);
        wait_drained();

        send_idle_pct = 61;
        recv_idle_pct = 7;
        push_random_text(140);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        push_random_text(70);
        // Nest past the depth limit, close a few levels, then end the text
        // while the subshell is still open.
        push_eoi();
        push_ch(CH_DOLLAR);
        push_ch(CH_LPAREN);
        for (int i = 0; i < MAX_DEPTH + 1; i++)
            push_ch(CH_LPAREN);
        for (int i = 0; i < 8; i++)
            push_ch(CH_RPAREN);
        push_eoi();
        push_random_text(50);
        push_eoi();
        stall_go = 1'b1;
        wait_drained();

        repeat (10) @(negedge aclk);
        if (error_count == 0 && expected_tokens.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/sat_pkg.sv
hw/rtl/sat_front.sv
hw/rtl/sat_fifo.sv
hw/rtl/sat_back.sv
hw/rtl/shell_arith_tokenizer.sv
hw/rtl/sat_checker.sv
verif/tb_shell_arith_tokenizer.sv
